[rtl/sld_pkg.sv]
package sld_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_DEPTH = MAX_PAYLOAD + 6;
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int FLEN_W      = 6;
    localparam int HDR_BYTES   = 5;
    localparam int HDR_W       = 3;
    localparam int TDATA_W     = 24;

    localparam logic [7:0] SYNC_BYTE    = 8'h55;
    localparam logic [7:0] SYNC2_BYTE   = 8'h88;
    localparam logic [7:0] TRAILER_BYTE = 8'hAA;

    typedef struct packed {
        logic             shift;
        logic             load;
        logic [IDX_W-1:0] wr_idx;
        logic [7:0]       load_byte;
        logic [IDX_W-1:0] tail_idx;
    } chain_ctrl_t;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic       tail_hit;
    } chain_stat_t;

endpackage

[rtl/sld_cell.sv]
module sld_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic       load,
    input  logic [7:0] load_byte,
    input  logic [7:0] neighbour_byte,
    input  logic       tail_sel,
    output logic [7:0] cell_byte,
    output logic       tail_hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (load)
        begin
            byte_next = load_byte;
        end
        else if (shift)
        begin
            byte_next = neighbour_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;
    assign tail_hit  = tail_sel && (byte_reg == sld_pkg::TRAILER_BYTE);

endmodule

[rtl/sld_chain.sv]
module sld_chain (
    input  logic                clk,
    input  sld_pkg::chain_ctrl_t ctrl,
    output sld_pkg::chain_stat_t stat
);

    logic [7:0] bytes [sld_pkg::STORE_DEPTH];
    logic [sld_pkg::STORE_DEPTH-1:0] hits;

    genvar i;
    generate
        for (i = 0; i < sld_pkg::STORE_DEPTH; i++)
        begin : g_cell
            logic [7:0] nb;
            if (i == sld_pkg::STORE_DEPTH - 1)
            begin : g_end
                assign nb = 8'h00;
            end
            else
            begin : g_mid
                assign nb = bytes[i+1];
            end

            sld_cell u_cell (
                .clk            (clk),
                .shift          (ctrl.shift),
                .load           (ctrl.load && (ctrl.wr_idx == sld_pkg::IDX_W'(i))),
                .load_byte      (ctrl.load_byte),
                .neighbour_byte (nb),
                .tail_sel       (ctrl.tail_idx == sld_pkg::IDX_W'(i)),
                .cell_byte      (bytes[i]),
                .tail_hit       (hits[i])
            );
        end
    endgenerate

    assign stat.b0       = bytes[0];
    assign stat.b1       = bytes[1];
    assign stat.b2       = bytes[2];
    assign stat.b3       = bytes[3];
    assign stat.b4       = bytes[4];
    assign stat.tail_hit = |hits;

endmodule

[rtl/sync_length_frame_deframer.sv]
// scan: after a byte is accepted the store is rescanned, one store byte dropped per cycle,
// and ready stays low until the scan returns to idle when no frame completes
// a completed frame drops 5 header bytes, emits one beat per payload byte, drops the trailer
// input: one serial byte per scan pass, taken only while the block is idle
// reset: asynchronous active-low, clears fill count, state and output valid; byte cells
// keep undefined contents until written
module sync_length_frame_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // frame_command, frame_length, payload_byte, zero pad
    output logic        m_axis_tlast    // last_of_frame
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HDR,
        ST_EMIT,
        ST_TRAIL
    } state_t;

    state_t                       state_reg, state_next;
    logic [sld_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [sld_pkg::HDR_W-1:0]    hdr_cnt_reg, hdr_cnt_next;
    logic [sld_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [sld_pkg::LEN_W-1:0]    emit_cnt_reg, emit_cnt_next;
    logic [7:0]                   cmd_reg, cmd_next;
    logic [sld_pkg::FLEN_W-1:0]   flen_reg, flen_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_byte_reg, out_byte_next;
    logic                         out_last_reg, out_last_next;
    logic [7:0]                   out_cmd_reg, out_cmd_next;
    logic [sld_pkg::FLEN_W-1:0]   out_len_reg, out_len_next;

    sld_pkg::chain_ctrl_t ctrl;
    sld_pkg::chain_stat_t stat;

    logic [15:0] hdr_len;
    logic [16:0] hdr_total;
    logic        len_bad;
    logic        s_fire;
    logic        out_free;

    sld_chain u_chain (
        .clk  (clk),
        .ctrl (ctrl),
        .stat (stat)
    );

    assign hdr_len   = {stat.b3, stat.b4};
    assign hdr_total = {1'b0, hdr_len} + 17'd6;
    assign len_bad   = (hdr_len == 16'd0) || (hdr_len > 16'(sld_pkg::MAX_PAYLOAD));
    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        len_next       = len_reg;
        emit_cnt_next  = emit_cnt_reg;
        cmd_next       = cmd_reg;
        flen_next      = flen_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_cmd_next   = out_cmd_reg;
        out_len_next   = out_len_reg;

        ctrl.shift     = 1'b0;
        ctrl.load      = 1'b0;
        ctrl.wr_idx    = fill_reg[sld_pkg::IDX_W-1:0];
        ctrl.load_byte = s_axis_tdata;
        // trailer position only matters once the length has passed its range check
        ctrl.tail_idx  = hdr_total[sld_pkg::IDX_W-1:0] - sld_pkg::IDX_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    // a full store ignores the byte
                    if (fill_reg < sld_pkg::FILL_W'(sld_pkg::STORE_DEPTH))
                    begin
                        ctrl.load = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (fill_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.b0 != sld_pkg::SYNC_BYTE)
                begin
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - 1'b1;
                end
                else if (fill_reg < sld_pkg::FILL_W'(2))
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.b1 != sld_pkg::SYNC2_BYTE)
                begin
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - 1'b1;
                end
                else if (fill_reg < sld_pkg::FILL_W'(5))
                begin
                    state_next = ST_IDLE;
                end
                else if (len_bad)
                begin
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - 1'b1;
                end
                else if (17'(fill_reg) < hdr_total)
                begin
                    state_next = ST_IDLE;
                end
                else if (!stat.tail_hit)
                begin
                    ctrl.shift = 1'b1;
                    fill_next  = fill_reg - 1'b1;
                end
                else
                begin
                    cmd_next      = stat.b2;
                    len_next      = hdr_len[sld_pkg::LEN_W-1:0];
                    flen_next     = hdr_len[sld_pkg::FLEN_W-1:0];
                    hdr_cnt_next  = '0;
                    emit_cnt_next = '0;
                    state_next    = ST_HDR;
                end
            end
            ST_HDR:
            begin
                ctrl.shift   = 1'b1;
                fill_next    = fill_reg - 1'b1;
                hdr_cnt_next = hdr_cnt_reg + 1'b1;
                if (hdr_cnt_reg == sld_pkg::HDR_W'(sld_pkg::HDR_BYTES - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ctrl.shift     = 1'b1;
                    fill_next      = fill_reg - 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = stat.b0;
                    out_cmd_next   = cmd_reg;
                    out_len_next   = flen_reg;
                    out_last_next  = (emit_cnt_reg == sld_pkg::LEN_W'(len_reg - 1'b1));
                    emit_cnt_next  = emit_cnt_reg + 1'b1;
                    if (emit_cnt_reg == sld_pkg::LEN_W'(len_reg - 1'b1))
                    begin
                        state_next = ST_TRAIL;
                    end
                end
            end
            ST_TRAIL:
            begin
                ctrl.shift = 1'b1;
                fill_next  = fill_reg - 1'b1;
                state_next = ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            hdr_cnt_reg   <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            hdr_cnt_reg   <= hdr_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        cmd_reg      <= cmd_next;
        flen_reg     <= flen_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_cmd_reg  <= out_cmd_next;
        out_len_reg  <= out_len_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_byte_reg, out_len_reg, out_cmd_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[rtl/sld_checker.sv]
module sld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // every accepted byte triggers a scan, which drops ready
    a_scan_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready stayed high after an accepted byte");

    // a new byte is only taken once the last beat of a frame has been issued
    a_idle_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
        else $error("input taken while a frame is still being emitted");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:22] == 2'b00)
        else $error("tdata pad bits not zero");

endmodule

bind sync_length_frame_deframer sld_checker u_sld_checker (.*);
